// ----- rtl/bba_pkg.sv -----
// Shared types, sizes and constant tables of the block bitmap allocator.
`timescale 1ns / 1ps

package bba_pkg;

    localparam int NUM_BLOCKS = 65536;
    localparam int STRIDE     = 1;

    localparam int BLK_W  = 16;
    localparam int CNT_W  = 17;
    localparam int VCNT_W = 18;
    localparam int WORD_W = 64;
    localparam int OFF_W  = 6;
    localparam int JMP_W  = 7;
    localparam int GAP_W  = 7;
    localparam int CEIL_W = 8;

    // Blocks that can ever be addressed: indices are 16 bits wide.
    localparam int MAX_BLOCKS = (NUM_BLOCKS < 65536) ? NUM_BLOCKS : 65536;
    localparam int WORD_COUNT = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
    localparam int WADDR_W    = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

    localparam logic [CNT_W-1:0] BLOCK_COUNT_RST = CNT_W'(65536);
    localparam logic [CNT_W-1:0] MAX_BLOCKS_C    = CNT_W'(MAX_BLOCKS);

    typedef enum logic [1:0] {
        FN_MARK_FREE = 2'd0,
        FN_MARK_USED = 2'd1,
        FN_QUERY     = 2'd2,
        FN_FIND      = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RMW,
        ST_REM,
        ST_SCAN,
        ST_PUSH
    } state_t;

    typedef logic [WORD_W-1:0][JMP_W-1:0] jump_tab_t;
    typedef logic [(1 << GAP_W)-1:0][CEIL_W-1:0] ceil_tab_t;

    // Bit b is set when b is a multiple of the stride.
    function automatic logic [WORD_W-1:0] gen_stride_pat();
        logic [WORD_W-1:0] pat;
        int                k;
        pat = '0;
        k   = 0;
        while (k < WORD_W)
        begin
            pat[k] = 1'b1;
            k      = k + STRIDE;
        end
        return pat;
    endfunction

    // Distance from a bit offset to the first probe past the end of the word.
    function automatic jump_tab_t gen_jump_tab();
        jump_tab_t tab;
        int        k;
        for (int o = 0; o < WORD_W; o++)
        begin
            k = 0;
            while (k < WORD_W - o)
            begin
                k = k + STRIDE;
            end
            tab[o] = JMP_W'(k);
        end
        return tab;
    endfunction

    // Smallest multiple of the stride at or above each distance.
    function automatic ceil_tab_t gen_ceil_tab();
        ceil_tab_t tab;
        int        k;
        for (int d = 0; d < (1 << GAP_W); d++)
        begin
            k = 0;
            while (k < d)
            begin
                k = k + STRIDE;
            end
            tab[d] = CEIL_W'(k);
        end
        return tab;
    endfunction

    localparam logic [WORD_W-1:0] STRIDE_PAT = gen_stride_pat();
    localparam jump_tab_t         JUMP_TAB   = gen_jump_tab();
    localparam ceil_tab_t         CEIL_TAB   = gen_ceil_tab();

endpackage

// ----- rtl/block_bitmap_allocator_core.sv -----
// Top level of the block bitmap allocator: sequencer, bitmap memory and counters.
//
//   channel   | signals                              | direction
//   ----------+--------------------------------------+----------
//   config    | cfg_write, cfg_data                  | in
//   request   | in_valid/in_ready, func, block       | in
//   result    | out_valid/out_ready, ok, bit_value,  | out
//             | found_block, valid_count             |
//
// Mark and query pass through accept, a read-modify-write of a 64-bit word, and result.
// An index out of range skips the read-modify-write step.
// A search reads one bitmap word per scan step (up to words + 1 with wrap), and first runs
// the remainder unit when the start block is at or above the block count.
// After reset a clearing pass sets the 1024 bitmap words to free, one word a cycle, while
// in_ready stays low; configuration writes are taken meanwhile.
// A result waits in the output register while out_ready is low; a new request is accepted then.
`timescale 1ns / 1ps

module block_bitmap_allocator_core
    import bba_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic [CNT_W-1:0]         cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [1:0]               func,
    input  logic [BLK_W-1:0]         block,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     ok,
    output logic                     bit_value,
    output logic [BLK_W-1:0]         found_block,
    output logic signed [VCNT_W-1:0] valid_count
);

    state_t             state_reg, state_next;
    func_t              func_reg, func_next;
    logic [BLK_W-1:0]   start_reg, start_next;
    logic [CNT_W-1:0]   pos_reg, pos_next;
    logic               phase_reg, phase_next;
    logic               res_ok_reg, res_ok_next;
    logic               res_bit_reg, res_bit_next;
    logic [BLK_W-1:0]   res_found_reg, res_found_next;
    logic [VCNT_W-1:0]  counter_reg, counter_next;
    logic [CNT_W-1:0]   block_count_reg, block_count_next;
    logic [WADDR_W-1:0] clear_cnt_reg, clear_cnt_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_ok_reg, out_ok_next;
    logic               out_bit_reg, out_bit_next;
    logic [BLK_W-1:0]   out_found_reg, out_found_next;
    logic [VCNT_W-1:0]  out_count_reg, out_count_next;
    logic [WORD_W-1:0]  rdata_reg;

    logic [WORD_W-1:0]  mem_q [WORD_COUNT];

    logic               mem_we;
    logic [WADDR_W-1:0] mem_waddr;
    logic [WORD_W-1:0]  mem_wdata;
    logic [WADDR_W-1:0] mem_raddr;
    logic               rem_start;
    logic               load_out;

    func_t              in_func;
    logic [CNT_W-1:0]   eff_n;
    logic               in_range;
    logic [CNT_W-1:0]   start_ext;
    logic [CNT_W-1:0]   scan_bound;
    logic               scan_hit;
    logic [BLK_W-1:0]   scan_hit_pos;
    logic [CNT_W-1:0]   scan_np;
    logic [CNT_W-1:0]   scan_gap;
    logic [CNT_W-1:0]   wrap_pos;
    logic               scan_cont;
    logic [CNT_W-1:0]   scan_pos;
    logic               scan_phase;
    logic               rem_done;
    logic [BLK_W-1:0]   rem_value;
    logic [OFF_W-1:0]   boff;
    logic [WORD_W-1:0]  bit_mask;

    bba_rem_unit u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (rem_start),
        .dividend  (block),
        .divisor   (eff_n),
        .done      (rem_done),
        .remainder (rem_value)
    );

    bba_word_scan u_scan (
        .pos      (pos_reg),
        .bound    (scan_bound),
        .word     (rdata_reg),
        .hit      (scan_hit),
        .hit_pos  (scan_hit_pos),
        .next_pos (scan_np)
    );

    always_comb
    begin
        in_func   = func_t'(func);
        eff_n     = (block_count_reg > MAX_BLOCKS_C) ? MAX_BLOCKS_C : block_count_reg;
        in_range  = ({1'b0, block} < eff_n);
        start_ext = {1'b0, start_reg};
        boff      = start_reg[OFF_W-1:0];
        bit_mask  = WORD_W'(1) << boff;
    end

    // Search continuation: first up to the block count, then wrapped up to the start.
    always_comb
    begin
        scan_bound = phase_reg ? start_ext : eff_n;
        // The wrapped search resumes at the first probe at or past the block count,
        // less the count.
        scan_gap   = eff_n - pos_reg;
        wrap_pos   = CNT_W'(CEIL_TAB[scan_gap[GAP_W-1:0]]) - scan_gap;
        scan_cont  = 1'b0;
        scan_pos   = scan_np;
        scan_phase = phase_reg;
        if (!phase_reg)
        begin
            if (scan_np < eff_n)
            begin
                scan_cont = 1'b1;
            end
            else if (wrap_pos < start_ext)
            begin
                scan_cont  = 1'b1;
                scan_pos   = wrap_pos;
                scan_phase = 1'b1;
            end
        end
        else if (scan_np < start_ext)
        begin
            scan_cont = 1'b1;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clear_cnt_reg == WADDR_W'(WORD_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_func == FN_FIND)
                    begin
                        if (eff_n == '0)
                        begin
                            state_next = ST_PUSH;
                        end
                        else if (in_range)
                        begin
                            state_next = ST_SCAN;
                        end
                        else
                        begin
                            state_next = ST_REM;
                        end
                    end
                    else
                    begin
                        state_next = in_range ? ST_RMW : ST_PUSH;
                    end
                end
            end
            ST_RMW:
            begin
                state_next = ST_PUSH;
            end
            ST_REM:
            begin
                if (rem_done)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_hit || !scan_cont)
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control outputs of the sequencer.
    always_comb
    begin
        in_ready  = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = WADDR_W'(start_reg >> OFF_W);
        mem_wdata = rdata_reg;
        mem_raddr = WADDR_W'(pos_reg >> OFF_W);
        rem_start = 1'b0;
        load_out  = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clear_cnt_reg;
                mem_wdata = '1;
            end
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                mem_raddr = WADDR_W'(block >> OFF_W);
            end
            ST_RMW:
            begin
                if (func_reg != FN_QUERY)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = (func_reg == FN_MARK_FREE) ? (rdata_reg | bit_mask)
                                                           : (rdata_reg & ~bit_mask);
                end
            end
            ST_REM:
            begin
                mem_raddr = WADDR_W'(rem_value >> OFF_W);
            end
            ST_SCAN:
            begin
                mem_raddr = WADDR_W'(scan_pos >> OFF_W);
            end
            ST_PUSH:
            begin
                load_out = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
        // The remainder unit is launched as the search request is accepted.
        if (state_reg == ST_IDLE && in_valid && in_func == FN_FIND && eff_n != '0 && !in_range)
        begin
            rem_start = 1'b1;
        end
    end

    // Datapath next values.
    always_comb
    begin
        func_next        = func_reg;
        start_next       = start_reg;
        pos_next         = pos_reg;
        phase_next       = phase_reg;
        res_ok_next      = res_ok_reg;
        res_bit_next     = res_bit_reg;
        res_found_next   = res_found_reg;
        counter_next     = counter_reg;
        clear_cnt_next   = clear_cnt_reg;
        block_count_next = cfg_write ? cfg_data : block_count_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_ok_next      = out_ok_reg;
        out_bit_next     = out_bit_reg;
        out_found_next   = out_found_reg;
        out_count_next   = out_count_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clear_cnt_next = clear_cnt_reg + WADDR_W'(1);
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    func_next      = in_func;
                    start_next     = block;
                    pos_next       = {1'b0, block};
                    phase_next     = 1'b0;
                    res_ok_next    = 1'b0;
                    res_bit_next   = 1'b0;
                    res_found_next = '0;
                end
            end
            ST_RMW:
            begin
                res_ok_next = 1'b1;
                case (func_reg)
                    FN_QUERY:     res_bit_next = rdata_reg[boff];
                    FN_MARK_FREE: counter_next = counter_reg - VCNT_W'(1);
                    FN_MARK_USED: counter_next = counter_reg + VCNT_W'(1);
                    default:      res_ok_next  = 1'b1;
                endcase
            end
            ST_REM:
            begin
                if (rem_done)
                begin
                    start_next = rem_value;
                    pos_next   = {1'b0, rem_value};
                end
            end
            ST_SCAN:
            begin
                if (scan_hit)
                begin
                    res_ok_next    = 1'b1;
                    res_found_next = scan_hit_pos;
                end
                else if (scan_cont)
                begin
                    pos_next   = scan_pos;
                    phase_next = scan_phase;
                end
            end
            ST_PUSH:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    out_ok_next    = res_ok_reg;
                    out_bit_next   = res_bit_reg;
                    out_found_next = res_found_reg;
                    out_count_next = counter_reg;
                end
            end
            default:
            begin
                pos_next = pos_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clear_cnt_reg   <= '0;
            counter_reg     <= '0;
            block_count_reg <= BLOCK_COUNT_RST;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clear_cnt_reg   <= clear_cnt_next;
            counter_reg     <= counter_next;
            block_count_reg <= block_count_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg      <= func_next;
        start_reg     <= start_next;
        pos_reg       <= pos_next;
        phase_reg     <= phase_next;
        res_ok_reg    <= res_ok_next;
        res_bit_reg   <= res_bit_next;
        res_found_reg <= res_found_next;
        out_ok_reg    <= out_ok_next;
        out_bit_reg   <= out_bit_next;
        out_found_reg <= out_found_next;
        out_count_reg <= out_count_next;
    end

    // Bitmap memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_q[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem_q[mem_raddr];
    end

    assign out_valid   = out_valid_reg;
    assign ok          = out_ok_reg;
    assign bit_value   = out_bit_reg;
    assign found_block = out_found_reg;
    assign valid_count = signed'(out_count_reg);

endmodule

// ----- rtl/bba_rem_unit.sv -----
// Restoring remainder unit that reduces a search start modulo the block count.
`timescale 1ns / 1ps

module bba_rem_unit
    import bba_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [BLK_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output logic             done,
    output logic [BLK_W-1:0] remainder
);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [3:0]         step_reg, step_next;
    logic [CNT_W-1:0]   rem_reg, rem_next;
    logic [BLK_W-1:0]   dvd_reg, dvd_next;
    logic [CNT_W-1:0]   dsr_reg, dsr_next;
    logic [CNT_W:0]     trial;
    logic [CNT_W:0]     diff;

    always_comb
    begin
        trial     = {rem_reg, dvd_reg[BLK_W-1]};
        diff      = trial - {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            dvd_next  = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            // The partial remainder stays below the divisor, so it fits 17 bits.
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = diff[CNT_W-1:0];
            end
            else
            begin
                rem_next = trial[CNT_W-1:0];
            end
            dvd_next  = {dvd_reg[BLK_W-2:0], 1'b0};
            step_next = step_reg + 4'd1;
            if (step_reg == 4'(BLK_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg[BLK_W-1:0];

endmodule

// ----- rtl/bba_word_scan.sv -----
// Evaluates one bitmap word of a free-block search and finds the next probe position.
`timescale 1ns / 1ps

module bba_word_scan
    import bba_pkg::*;
(
    input  logic [CNT_W-1:0]  pos,
    input  logic [CNT_W-1:0]  bound,
    input  logic [WORD_W-1:0] word,
    output logic              hit,
    output logic [BLK_W-1:0]  hit_pos,
    output logic [CNT_W-1:0]  next_pos
);

    localparam int WNUM_W = CNT_W - OFF_W;

    logic [WNUM_W-1:0] pos_w;
    logic [WNUM_W-1:0] bound_w;
    logic [WORD_W-1:0] lim_mask;
    logic [WORD_W-1:0] cand;
    logic [OFF_W-1:0]  idx;

    always_comb
    begin
        pos_w   = pos[CNT_W-1:OFF_W];
        bound_w = bound[CNT_W-1:OFF_W];
        // Only probes below the bound of the current search phase count.
        if (bound_w > pos_w)
        begin
            lim_mask = '1;
        end
        else if (bound_w == pos_w)
        begin
            lim_mask = (WORD_W'(1) << bound[OFF_W-1:0]) - WORD_W'(1);
        end
        else
        begin
            lim_mask = '0;
        end
        cand = word & (STRIDE_PAT << pos[OFF_W-1:0]) & lim_mask;
        idx  = '0;
        for (int b = WORD_W - 1; b >= 0; b--)
        begin
            if (cand[b])
            begin
                idx = OFF_W'(b);
            end
        end
        hit      = |cand;
        hit_pos  = {pos[BLK_W-1:OFF_W], idx};
        next_pos = pos + CNT_W'(JUMP_TAB[pos[OFF_W-1:0]]);
    end

endmodule

// ----- rtl/bba_checker.sv -----
// Port-level assertions for the block bitmap allocator, bound to the top level.
`timescale 1ns / 1ps

module bba_checker
    import bba_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     cfg_write,
    input logic [CNT_W-1:0]         cfg_data,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic [1:0]               func,
    input logic [BLK_W-1:0]         block,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic                     ok,
    input logic                     bit_value,
    input logic [BLK_W-1:0]         found_block,
    input logic signed [VCNT_W-1:0] valid_count
);

    // A waiting result is held until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(found_block) && $stable(valid_count))
    else $error("result changed or dropped while stalled");

    // The block works on one request at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("request accepted while the previous one is still at work");

    // A failed request reports neither a bit nor a block.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !ok |-> !bit_value && found_block == '0)
    else $error("failed result carries data");

    // A nonzero block number only comes from a successful search.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found_block != '0 |-> ok && !bit_value)
    else $error("found block without a successful search");

endmodule

bind block_bitmap_allocator_core bba_checker u_bba_checker (.*);
